// ----- rtl/kds_pkg.sv -----
package kds_pkg;

    localparam int COUNT_BITS = 10;
    localparam int THR_BITS   = 8;
    localparam int CODE_BITS  = 4;
    localparam int NUM_COLS   = 3;
    localparam int NUM_ROWS   = 4;

    typedef struct packed {
        logic [NUM_COLS-1:0] column_lines;
        logic [NUM_ROWS-1:0] row_lines;
    } sample_t;

    typedef struct packed {
        logic                 release_event;
        logic [CODE_BITS-1:0] release_code;
        logic                 key_held;
        logic [CODE_BITS-1:0] held_code;
    } result_t;

    function automatic logic [CODE_BITS-1:0] key_code(input logic [1:0] row,
                                                      input logic [1:0] col);
        logic [CODE_BITS-1:0] code;
        code = '0;
        unique case ({row, col})
            4'b00_00: code = 4'd1;
            4'b00_01: code = 4'd2;
            4'b00_10: code = 4'd3;
            4'b01_00: code = 4'd4;
            4'b01_01: code = 4'd5;
            4'b01_10: code = 4'd6;
            4'b10_00: code = 4'd7;
            4'b10_01: code = 4'd8;
            4'b10_10: code = 4'd9;
            4'b11_00: code = 4'd10;
            4'b11_01: code = 4'd0;
            4'b11_10: code = 4'd11;
            default:  code = '0;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/keypad_debounce_scanner_top.sv -----
// A sample passes through the input register and then the result register before its result is valid.
// Throughput: one sample word per cycle unless result_ready stalls the result register;
// the tracking state updates as a word moves from the input register into the result register.
// Reset (rst_n, async, active low): threshold returns to 5, tracking, confirmation,
// latched key and stability counter clear, both stages empty.
module keypad_debounce_scanner_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  kds_pkg::sample_t          sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output kds_pkg::result_t          result,
    input  logic                      cfg_write_en,
    input  logic [kds_pkg::THR_BITS-1:0] cfg_write_data
);
    import kds_pkg::*;

    localparam int CMP_BITS = COUNT_BITS + 1;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [THR_BITS-1:0]          thr_reg;
    logic                         in_valid_reg;
    sample_t                      in_reg;
    logic                         out_valid_reg;
    result_t                      out_reg;

    logic                         tracking_reg, tracking_next;
    logic                         confirmed_reg, confirmed_next;
    logic [1:0]                   col_reg, col_next;
    logic [1:0]                   row_reg, row_next;
    logic signed [COUNT_BITS-1:0] count_reg, count_next;
    result_t                      out_next;

    logic                         advance;
    logic                         col_hi, row_hi;
    logic [1:0]                   first_col, first_row, last_row;
    logic                         any_col, any_row;
    logic signed [CMP_BITS-1:0]   cnt_ext, thr_ext;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        any_col = |in_reg.column_lines;
        any_row = |in_reg.row_lines;

        if (in_reg.column_lines[0])
            first_col = 2'd0;
        else if (in_reg.column_lines[1])
            first_col = 2'd1;
        else
            first_col = 2'd2;

        if (in_reg.row_lines[0])
            first_row = 2'd0;
        else if (in_reg.row_lines[1])
            first_row = 2'd1;
        else if (in_reg.row_lines[2])
            first_row = 2'd2;
        else
            first_row = 2'd3;

        if (in_reg.row_lines[3])
            last_row = 2'd3;
        else if (in_reg.row_lines[2])
            last_row = 2'd2;
        else if (in_reg.row_lines[1])
            last_row = 2'd1;
        else
            last_row = 2'd0;

        col_hi = (col_reg == 2'd3) ? 1'b0 : in_reg.column_lines[col_reg];
        row_hi = in_reg.row_lines[row_reg];

        tracking_next  = tracking_reg;
        confirmed_next = confirmed_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        count_next     = count_reg;
        out_next       = '0;
        cnt_ext        = '0;
        thr_ext        = signed'({{(CMP_BITS-THR_BITS){1'b0}}, thr_reg});

        if (!tracking_reg)
        begin
            if (any_col && any_row)
            begin
                tracking_next  = 1'b1;
                confirmed_next = 1'b0;
                col_next       = first_col;
                row_next       = last_row;
                count_next     = '0;
            end
        end
        else
        begin
            if (col_hi)
            begin
                if (row_hi && count_reg != COUNT_MAX)
                    count_next = count_reg + COUNT_BITS'(1);
            end
            else if (count_reg != COUNT_MIN)
            begin
                count_next = count_reg - COUNT_BITS'(1);
            end

            cnt_ext = signed'({count_next[COUNT_BITS-1], count_next});
            if (cnt_ext > thr_ext)
                confirmed_next = 1'b1;
            if (cnt_ext < -thr_ext)
                tracking_next = 1'b0;
            if (confirmed_next && !col_hi && !row_hi)
            begin
                tracking_next         = 1'b0;
                confirmed_next        = 1'b0;
                out_next.release_event = 1'b1;
                out_next.release_code  = key_code(row_reg, col_reg);
            end
        end

        if (any_col && any_row)
        begin
            out_next.key_held  = 1'b1;
            out_next.held_code = key_code(first_row, first_col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_BITS'(5);
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tracking_reg  <= 1'b0;
            confirmed_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_write_en)
                thr_reg <= cfg_write_data;

            if (sample_ready)
                in_valid_reg <= sample_valid;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                tracking_reg  <= tracking_next;
                confirmed_reg <= confirmed_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
                count_reg     <= count_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload words without reset
    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
            in_reg <= sample;
        if (advance)
            out_reg <= out_next;
    end

endmodule
